/* rtl/core/mm_pkg.sv */
// Shared types and constants for the matrix multiply block.
// No dependencies; imported by mm_datapath, mm_ctrl and matrix_multiply_top.
package mm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int CFG_W       = 4;
    localparam int IDX_W       = 2;
    localparam int CMD_W       = 2;
    localparam int POS_W       = 3;
    localparam int VAL_W       = 32;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = 2 * VAL_W;

    // request codes on the cmd field
    localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MUL  = 2'd2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [IDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [IDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [IDX_W-1:0] REG_B_COLS = 2'd3;

    // tag that travels with each multiply-accumulate step
    typedef struct packed {
        logic             first;
        logic             lastk;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic issue;
        logic err;
        t_tag tag;
    } t_dp_cmd;

    typedef struct packed {
        logic pend;
    } t_dp_sts;

endpackage

/* rtl/core/mm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/mm_datapath.sv */
// Datapath: A/B element stores, signed multiplier, wide accumulator, saturation.
// Depends on mm_pkg and mm_ram.
module mm_datapath #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  mm_pkg::t_dp_cmd                         i_cmd,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      i_waddr,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      i_raddr_a,
    input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      i_raddr_b,
    input  logic signed [mm_pkg::VAL_W-1:0]         i_value,
    output mm_pkg::t_dp_sts                         o_sts,
    output logic                                    o_valid,
    output logic [mm_pkg::POS_W-1:0]                o_out_row,
    output logic [mm_pkg::POS_W-1:0]                o_out_col,
    output logic signed [mm_pkg::VAL_W-1:0]         o_out_value,
    output logic                                    o_last,
    output logic                                    o_error
);
    import mm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int ACC_W = PROD_W + $clog2(MAX_DIM + 1);
    localparam int SAT_L = FRAC_W + VAL_W - 1;

    logic [DEPTH-1:0]        r_a_vld, r_b_vld;
    logic [VAL_W-1:0]        ram_a, ram_b;
    logic                    r_a_ok, r_b_ok;
    logic signed [VAL_W-1:0] a_op, b_op;
    logic signed [PROD_W-1:0] mul;

    logic                     r_s1_vld, r_s2_vld, r_s3_vld;
    t_tag                     r_s1_tag, r_s2_tag, r_s3_tag;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:SAT_L]     acc_hi;
    logic                     fits;
    logic [VAL_W-1:0]         sat_val;

    logic                     r_o_valid, r_o_last, r_o_error;
    logic [POS_W-1:0]         r_o_row, r_o_col;
    logic [VAL_W-1:0]         r_o_value;

    mm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_a),
        .i_waddr (i_waddr),
        .i_wdata (i_value),
        .i_raddr (i_raddr_a),
        .o_rdata (ram_a)
    );

    mm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_b),
        .i_waddr (i_waddr),
        .i_wdata (i_value),
        .i_raddr (i_raddr_b),
        .o_rdata (ram_b)
    );

    // written-entry flags; unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= '0;
            r_b_vld <= '0;
        end else begin
            if (i_cmd.wr_a) begin
                r_a_vld[i_waddr] <= 1'b1;
            end
            if (i_cmd.wr_b) begin
                r_b_vld[i_waddr] <= 1'b1;
            end
        end
    end

    // stage 1: memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.issue;
        end
        r_s1_tag <= i_cmd.tag;
        r_a_ok   <= r_a_vld[i_raddr_a];
        r_b_ok   <= r_b_vld[i_raddr_b];
    end

    assign a_op = r_a_ok ? ram_a : '0;
    assign b_op = r_b_ok ? ram_b : '0;
    assign mul  = a_op * b_op;

    // stage 2: product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_tag <= r_s1_tag;
        r_prod   <= mul;
    end

    // stage 3: accumulate at full width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_tag <= r_s2_tag;
        if (r_s2_vld) begin
            if (r_s2_tag.first) begin
                r_acc <= ACC_W'(r_prod);
            end else begin
                r_acc <= r_acc + ACC_W'(r_prod);
            end
        end
    end

    // floor shift by FRAC_W, saturate to VAL_W
    assign acc_hi  = r_acc[ACC_W-1:SAT_L];
    assign fits    = (acc_hi == '0) || (acc_hi == '1);
    assign sat_val = fits ? r_acc[SAT_L:FRAC_W]
                   : (r_acc[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                     : {1'b0, {(VAL_W-1){1'b1}}});

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= i_cmd.err || (r_s3_vld && r_s3_tag.lastk);
        end
        if (i_cmd.err) begin
            r_o_row   <= '0;
            r_o_col   <= '0;
            r_o_value <= '0;
            r_o_last  <= 1'b1;
            r_o_error <= 1'b1;
        end else begin
            r_o_row   <= r_s3_tag.row;
            r_o_col   <= r_s3_tag.col;
            r_o_value <= sat_val;
            r_o_last  <= r_s3_tag.last;
            r_o_error <= 1'b0;
        end
    end

    assign o_sts.pend  = r_s1_vld || r_s2_vld || r_s3_vld;
    assign o_valid     = r_o_valid;
    assign o_out_row   = r_o_row;
    assign o_out_col   = r_o_col;
    assign o_out_value = r_o_value;
    assign o_last      = r_o_last;
    assign o_error     = r_o_error;

    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.err |-> !(r_s1_vld || r_s2_vld || r_s3_vld))
        else $error("mismatch result raised while products in flight");

    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.err |=> o_valid && o_last && o_error && (o_out_value == '0))
        else $error("mismatch result malformed");

    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_vld && r_s3_tag.lastk) |=> o_valid && !o_error)
        else $error("finished sum not emitted");

endmodule

/* rtl/core/mm_ctrl.sv */
// Controller: configuration registers, request decode and the i/j/k walk.
// Depends on mm_pkg.
module mm_ctrl #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mm_pkg::CMD_W-1:0]            i_cmd,
    input  logic [mm_pkg::POS_W-1:0]            i_row,
    input  logic [mm_pkg::POS_W-1:0]            i_col,
    input  logic                                i_cfg_we,
    input  logic [mm_pkg::IDX_W-1:0]            i_cfg_idx,
    input  logic [mm_pkg::CFG_W-1:0]            i_cfg_data,
    input  mm_pkg::t_dp_sts                     i_sts,
    output mm_pkg::t_dp_cmd                     o_cmd,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  o_waddr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  o_raddr_a,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]  o_raddr_b
);
    import mm_pkg::*;

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);
    localparam int IW = $clog2(MAX_DIM);
    localparam int EW = $clog2(MAX_DIM + 1);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    function automatic logic [EW-1:0] eff_dim(input logic [CFG_W-1:0] d);
        if (d == '0) begin
            return EW'(1);
        end else if (int'(d) > MAX_DIM) begin
            return EW'(MAX_DIM);
        end
        return EW'(d);
    endfunction

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [IW-1:0]    r_i, r_j, r_k, n_i, n_j, n_k;
    logic [EW-1:0]    eff_ar, eff_ac, eff_br, eff_bc;
    logic             accept, mismatch, k_end, j_end, i_end;
    logic             do_wr_a, do_wr_b, do_mul, do_err;

    assign eff_ar = eff_dim(r_a_rows);
    assign eff_ac = eff_dim(r_a_cols);
    assign eff_br = eff_dim(r_b_rows);
    assign eff_bc = eff_dim(r_b_cols);

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign mismatch = (eff_ac != eff_br);

    // request decode; out-of-range loads drop silently
    always_comb begin
        do_wr_a = 1'b0;
        do_wr_b = 1'b0;
        do_mul  = 1'b0;
        do_err  = 1'b0;
        if (accept) begin
            unique case (i_cmd)
                CMD_WR_A: do_wr_a = (int'(i_row) < int'(eff_ar)) &&
                                    (int'(i_col) < int'(eff_ac));
                CMD_WR_B: do_wr_b = (int'(i_row) < int'(eff_br)) &&
                                    (int'(i_col) < int'(eff_bc));
                CMD_MUL: begin
                    do_mul = !mismatch;
                    do_err = mismatch;
                end
                default: ;
            endcase
        end
    end

    assign k_end = (int'(r_k) + 1 == int'(eff_ac));
    assign j_end = (int'(r_j) + 1 == int'(eff_bc));
    assign i_end = (int'(r_i) + 1 == int'(eff_ar));

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (do_mul) begin
                    n_state = S_RUN;
                    n_i     = '0;
                    n_j     = '0;
                    n_k     = '0;
                end
            end
            S_RUN: begin
                if (!k_end) begin
                    n_k = r_k + 1'b1;
                end else begin
                    n_k = '0;
                    if (!j_end) begin
                        n_j = r_j + 1'b1;
                    end else begin
                        n_j = '0;
                        if (!i_end) begin
                            n_i = r_i + 1'b1;
                        end else begin
                            n_state = S_DRAIN;
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (!i_sts.pend) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_a_rows <= CFG_W'(1);
            r_a_cols <= CFG_W'(1);
            r_b_rows <= CFG_W'(1);
            r_b_cols <= CFG_W'(1);
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_A_ROWS: r_a_rows <= i_cfg_data;
                    REG_A_COLS: r_a_cols <= i_cfg_data;
                    REG_B_ROWS: r_b_rows <= i_cfg_data;
                    REG_B_COLS: r_b_cols <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_waddr   = AW'(int'(i_row) * MAX_DIM + int'(i_col));
    assign o_raddr_a = AW'(int'(r_i) * MAX_DIM + int'(r_k));
    assign o_raddr_b = AW'(int'(r_k) * MAX_DIM + int'(r_j));

    always_comb begin
        o_cmd           = '0;
        o_cmd.wr_a      = do_wr_a;
        o_cmd.wr_b      = do_wr_b;
        o_cmd.err       = do_err;
        o_cmd.issue     = (r_state == S_RUN);
        o_cmd.tag.first = (r_k == '0);
        o_cmd.tag.lastk = k_end;
        o_cmd.tag.last  = k_end && j_end && i_end;
        o_cmd.tag.row   = POS_W'(r_i);
        o_cmd.tag.col   = POS_W'(r_j);
    end

    a_run_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_mul |=> (r_state == S_RUN) && (r_i == '0) && (r_j == '0) && (r_k == '0))
        else $error("product walk did not start clean");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.issue && o_cmd.tag.last) |=> (r_state == S_DRAIN))
        else $error("walk did not stop after final step");

    a_err_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_err |=> (r_state == S_IDLE) && !o_cmd.issue)
        else $error("mismatch started a walk");

endmodule

/* rtl/core/matrix_multiply_top.sv */
// Matrix multiply block, top level: config port, request port, result strobe.
// Loads never raise busy. A product request runs N = ar*bc*ac issue steps
// (one multiply-accumulate per cycle, set by the single multiplier and the one read port
// of each element store); busy holds until the final result shows.
// A dimension mismatch gives its error result the next cycle. The receiver cannot
// stall. Reset (sync, active low) sets all dims to 1 and makes every element read 0.
module matrix_multiply_top #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [mm_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [mm_pkg::CFG_W-1:0]     i_cfg_data,
    // request port
    input  logic                         start,
    output logic                         busy,
    input  logic [mm_pkg::CMD_W-1:0]     i_cmd,
    input  logic [mm_pkg::POS_W-1:0]     i_row,
    input  logic [mm_pkg::POS_W-1:0]     i_col,
    input  logic signed [mm_pkg::VAL_W-1:0] i_value,
    // result strobe and fields
    output logic                         o_valid,
    output logic [mm_pkg::POS_W-1:0]     o_out_row,
    output logic [mm_pkg::POS_W-1:0]     o_out_col,
    output logic signed [mm_pkg::VAL_W-1:0] o_out_value,
    output logic                         o_last,
    output logic                         o_error
);
    import mm_pkg::*;

    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    // control to datapath: decoded request, walk step tags
    t_dp_cmd       dp_cmd;
    // datapath back to control: products still in the pipe
    t_dp_sts       dp_sts;
    logic [AW-1:0] waddr, raddr_a, raddr_b;

    // Controller owns the dimension registers, decodes each request (bounds
    // check on loads, inner-dimension check on products) and walks i, j, k.
    mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd),
        .o_waddr    (waddr),
        .o_raddr_a  (raddr_a),
        .o_raddr_b  (raddr_b)
    );

    // Datapath: read -> multiply -> accumulate -> shift/saturate/output, one
    // register per step; the accumulator is wide enough that no sum overflows.
    mm_datapath #(.MAX_DIM(MAX_DIM)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_waddr     (waddr),
        .i_raddr_a   (raddr_a),
        .i_raddr_b   (raddr_b),
        .i_value     (i_value),
        .o_sts       (dp_sts),
        .o_valid     (o_valid),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule

/* tb/matrix_multiply_checker.sv */
// Product checker for matrix_multiply_top: tracks the element stores and dimension
// registers, predicts every result of each accepted request and compares them in order.
// Depends on mm_pkg for widths, request codes and register indexes.
module matrix_multiply_checker #(
    parameter int MAX_DIM = mm_pkg::MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mm_pkg::IDX_W-1:0]        i_cfg_idx,
    input  logic [mm_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic [mm_pkg::CMD_W-1:0]        i_cmd,
    input  logic [mm_pkg::POS_W-1:0]        i_row,
    input  logic [mm_pkg::POS_W-1:0]        i_col,
    input  logic [mm_pkg::VAL_W-1:0]        i_value,
    input  logic                            i_valid,
    input  logic [mm_pkg::POS_W-1:0]        i_out_row,
    input  logic [mm_pkg::POS_W-1:0]        i_out_col,
    input  logic [mm_pkg::VAL_W-1:0]        i_out_value,
    input  logic                            i_last,
    input  logic                            i_error,
    output int                              o_pending_count,
    output int                              o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import mm_pkg::*;

    localparam int ACC_W = PROD_W + 16;
    localparam logic signed [ACC_W-1:0] SAT_HI = 2147483647;
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;

    typedef struct {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [VAL_W-1:0] value;
        logic             last;
        logic             error;
    } t_product_elem;

    t_product_elem    expected_products[$];
    logic [VAL_W-1:0] a_elems [MAX_DIM*MAX_DIM];
    logic [VAL_W-1:0] b_elems [MAX_DIM*MAX_DIM];
    logic [CFG_W-1:0] dims [4];
    int               fail_count = 0;

    // 0 acts as 1, anything above MAX_DIM as MAX_DIM
    function automatic int eff_dim(logic [CFG_W-1:0] d);
        if (d == 0) return 1;
        if (d > MAX_DIM) return MAX_DIM;
        return int'(d);
    endfunction

    // floor shift of the Q48.32 sum back to Q16.16, clamped to 32 bits
    function automatic logic [VAL_W-1:0] shift_saturate(logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        sh = acc >>> FRAC_W;
        if (sh > SAT_HI) return 32'h7FFF_FFFF;
        if (sh < SAT_LO) return 32'h8000_0000;
        return sh[VAL_W-1:0];
    endfunction

    function automatic void apply_request(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] row,
                                          logic [POS_W-1:0] col, logic [VAL_W-1:0] value);
        int ar, ac, br, bc, i, j, k;
        logic signed [ACC_W-1:0] acc, fa, fb;
        t_product_elem elem;
        ar = eff_dim(dims[REG_A_ROWS]);
        ac = eff_dim(dims[REG_A_COLS]);
        br = eff_dim(dims[REG_B_ROWS]);
        bc = eff_dim(dims[REG_B_COLS]);
        case (cmd)
            CMD_WR_A: if (row < ar && col < ac) a_elems[row*MAX_DIM + col] = value;
            CMD_WR_B: if (row < br && col < bc) b_elems[row*MAX_DIM + col] = value;
            CMD_MUL: begin
                if (ac != br) begin
                    elem.row = '0;
                    elem.col = '0;
                    elem.value = '0;
                    elem.last = 1'b1;
                    elem.error = 1'b1;
                    expected_products.push_back(elem);
                end else begin
                    for (i = 0; i < ar; i++) begin
                        for (j = 0; j < bc; j++) begin
                            acc = '0;
                            for (k = 0; k < ac; k++) begin
                                fa = $signed(a_elems[i*MAX_DIM + k]);
                                fb = $signed(b_elems[k*MAX_DIM + j]);
                                acc = acc + fa * fb;
                            end
                            elem.row = POS_W'(i);
                            elem.col = POS_W'(j);
                            elem.value = shift_saturate(acc);
                            elem.last = (i == ar - 1) && (j == bc - 1);
                            elem.error = 1'b0;
                            expected_products.push_back(elem);
                        end
                    end
                end
            end
            default: ;  // unused code, no effect
        endcase
    endfunction

    function automatic void check_result();
        t_product_elem want;
        if (expected_products.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("[%0t] result with none pending: row %0d col %0d value %h %s",
                         $time, i_out_row, i_out_col, i_out_value,
                         $sformatf("last %b err %b", i_last, i_error));
            return;
        end
        want = expected_products.pop_front();
        if (i_out_row !== want.row || i_out_col !== want.col || i_out_value !== want.value ||
            i_last !== want.last || i_error !== want.error) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("[%0t] mismatch: want row %0d col %0d value %h last %b err %b",
                         $time, want.row, want.col, want.value, want.last, want.error);
                $display("               got  row %0d col %0d value %h last %b err %b",
                         i_out_row, i_out_col, i_out_value, i_last, i_error);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (a_elems[n]) a_elems[n] = '0;
            foreach (b_elems[n]) b_elems[n] = '0;
            foreach (dims[n]) dims[n] = CFG_W'(1);
            expected_products.delete();
        end else begin
            // results leaving at this edge belong to older requests
            if (i_valid) check_result();
            // a request taken at this edge still sees the old dimensions
            if (i_start && !i_busy) apply_request(i_cmd, i_row, i_col, i_value);
            if (i_cfg_we) dims[i_cfg_idx] = i_cfg_data;
        end
        o_pending_count <= expected_products.size();
        o_fail_count <= fail_count;
    end

endmodule

/* tb/matrix_multiply_top_tb.sv */
// Testbench top for matrix_multiply_top: clock, reset, dimension setup and request stimulus.
// Depends on mm_pkg, matrix_multiply_top and matrix_multiply_checker.
module matrix_multiply_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mm_pkg::*;

    localparam int MAXD = MAX_DIM_DEF;
    // the one cmd code the block has no use for; must be ignored
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [IDX_W-1:0]   i_cfg_idx = REG_A_ROWS;
    logic [CFG_W-1:0]   i_cfg_data = '0;
    logic               start = 1'b0;
    logic               busy;
    logic [CMD_W-1:0]   i_cmd = CMD_WR_A;
    logic [POS_W-1:0]   i_row = '0;
    logic [POS_W-1:0]   i_col = '0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic               o_valid;
    logic [POS_W-1:0]   o_out_row;
    logic [POS_W-1:0]   o_out_col;
    logic signed [VAL_W-1:0] o_out_value;
    logic               o_last;
    logic               o_error;

    int pending_count;
    int fail_count;
    int burst_left = 0;     // requests left in the current burst
    int items_sent = 0;     // requests taken by the block

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    matrix_multiply_top #(.MAX_DIM(MAXD)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_out_value (o_out_value),
        .o_last      (o_last),
        .o_error     (o_error)
    );

    // watches both sides, predicts and compares
    matrix_multiply_checker #(.MAX_DIM(MAXD)) u_product_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_start         (start),
        .i_busy          (busy),
        .i_cmd           (i_cmd),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_value         (i_value),
        .i_valid         (o_valid),
        .i_out_row       (o_out_row),
        .i_out_col       (o_out_col),
        .i_out_value     (o_out_value),
        .i_last          (o_last),
        .i_error         (o_error),
        .o_pending_count (pending_count),
        .o_fail_count    (fail_count)
    );

    // Present one request and hold it until the block takes it.
    // Called right after the clock rises; returns right after the rise that takes the request.
    // Bursts of random length, with random gaps in between; now and then a
    // long burst so that back-to-back requests also show up.
    task automatic issue_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] row,
                                 input logic [POS_W-1:0] col, input logic [VAL_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        start   <= 1'b1;
        i_cmd   <= cmd;
        i_row   <= row;
        i_col   <= col;
        i_value <= value;
        // busy sampled here is the value seen by the accepting edge
        do @(posedge i_clk); while (busy);
        items_sent++;
    endtask

    // Stop sending and wait until every predicted result is out and the
    // block is idle, then a little more so any tail activity settles.
    task automatic drain_products();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0 || busy);
        repeat (MAXD + 4) @(posedge i_clk);
    endtask

    // Write all four dimension registers, one per cycle. Block must be idle.
    task automatic load_dims(input logic [CFG_W-1:0] ar, input logic [CFG_W-1:0] ac,
                             input logic [CFG_W-1:0] br, input logic [CFG_W-1:0] bc);
        logic [IDX_W-1:0] reg_ids [4];
        logic [CFG_W-1:0] vals [4];
        reg_ids = '{REG_A_ROWS, REG_A_COLS, REG_B_ROWS, REG_B_COLS};
        vals = '{ar, ac, br, bc};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= reg_ids[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // clamp a raw dimension the way the block does (needed to aim loads)
    function automatic int clamp_dim(logic [CFG_W-1:0] d);
        if (d == 0) return 1;
        if (d > MAXD) return MAXD;
        return int'(d);
    endfunction

    // element values: extremes, zero, full random, and small Q16.16 in +/-8.0
    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 6))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3, 4:    return $urandom();
            default: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    // One phase: pick dimensions, load a matrix pair (mostly in-range loads,
    // some out-of-range or unused-code noise), request the product once or
    // twice, then drain so the next phase may rewrite the dimensions.
    task automatic run_random_phase();
        logic [CFG_W-1:0] d [4];
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] row, col;
        int sel, ar, ac, br, bc, nr, nc, loads, kind;
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
            // raw register values, out-of-range ones included
            foreach (d[n]) d[n] = CFG_W'($urandom_range(0, 15));
        end else if (sel <= 2) begin
            // large but rare: long multiply-accumulate walks
            d[0] = CFG_W'($urandom_range(5, 8));
            d[1] = CFG_W'($urandom_range(5, 8));
            d[3] = CFG_W'($urandom_range(5, 8));
            d[2] = d[1];
        end else begin
            d[0] = CFG_W'($urandom_range(1, 4));
            d[1] = CFG_W'($urandom_range(1, 4));
            d[3] = CFG_W'($urandom_range(1, 4));
            // mostly matched inner dimension, sometimes a mismatch
            d[2] = ($urandom_range(0, 9) == 0) ? CFG_W'($urandom_range(1, 4)) : d[1];
        end
        ar = clamp_dim(d[0]);
        ac = clamp_dim(d[1]);
        br = clamp_dim(d[2]);
        bc = clamp_dim(d[3]);
        load_dims(d[0], d[1], d[2], d[3]);

        repeat ($urandom_range(1, 2)) begin
            loads = ar * ac + br * bc + $urandom_range(0, 3);
            repeat (loads) begin
                kind = $urandom_range(0, 9);
                cmd  = $urandom_range(0, 1) ? CMD_WR_B : CMD_WR_A;
                nr   = (cmd == CMD_WR_A) ? ar : br;
                nc   = (cmd == CMD_WR_A) ? ac : bc;
                row  = POS_W'($urandom_range(0, nr - 1));
                col  = POS_W'($urandom_range(0, nc - 1));
                if (kind == 0) begin
                    // load outside the matrix: must be dropped
                    if (nr < MAXD) row = POS_W'($urandom_range(nr, MAXD - 1));
                    else if (nc < MAXD) col = POS_W'($urandom_range(nc, MAXD - 1));
                    else cmd = CMD_UNUSED;
                end else if (kind == 1) begin
                    cmd = CMD_UNUSED;
                    row = POS_W'($urandom_range(0, 7));
                    col = POS_W'($urandom_range(0, 7));
                end
                issue_request(cmd, row, col, random_value());
            end
            // row/col/value ride along on a product request and are ignored
            issue_request(CMD_MUL, POS_W'($urandom_range(0, 7)), POS_W'($urandom_range(0, 7)),
                          $urandom());
        end
        // every phase ends with the sender paused until all results are back
        drain_products();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        // Straight out of reset: 1x1 by 1x1, stores read zero.
        issue_request(CMD_MUL, 3'd0, 3'd0, 32'h0);
        drain_products();

        // 2x2 by 2x2 with extreme elements: both saturation directions.
        load_dims(4'd2, 4'd2, 4'd2, 4'd2);
        issue_request(CMD_WR_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
        issue_request(CMD_WR_A, 3'd0, 3'd1, 32'h7FFF_FFFF);
        issue_request(CMD_WR_A, 3'd1, 3'd0, 32'h8000_0000);
        issue_request(CMD_WR_A, 3'd1, 3'd1, 32'h8000_0000);
        issue_request(CMD_WR_B, 3'd0, 3'd0, 32'h7FFF_FFFF);
        issue_request(CMD_WR_B, 3'd1, 3'd0, 32'h7FFF_FFFF);
        issue_request(CMD_WR_B, 3'd0, 3'd1, 32'h8000_0000);
        issue_request(CMD_WR_B, 3'd1, 3'd1, 32'h0001_0000);
        // out-of-range loads and the unused code, all without effect
        issue_request(CMD_WR_A, 3'd2, 3'd0, 32'h1234_5678);
        issue_request(CMD_WR_B, 3'd0, 3'd7, 32'hFFFF_FFFF);
        issue_request(CMD_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF);
        issue_request(CMD_MUL, 3'd7, 3'd7, 32'hFFFF_FFFF);
        drain_products();

        // Raw 0 and values above the maximum: effective 1x8 by 8x1.
        load_dims(4'd0, 4'd15, 4'd9, 4'd0);
        issue_request(CMD_WR_A, 3'd0, 3'd7, 32'h0003_8000);
        issue_request(CMD_WR_B, 3'd7, 3'd0, 32'hFFFE_0000);
        issue_request(CMD_MUL, 3'd0, 3'd0, 32'h0);
        drain_products();

        // Inner dimensions differ: single error result.
        load_dims(4'd8, 4'd3, 4'd2, 4'd8);
        issue_request(CMD_MUL, 3'd0, 3'd0, 32'h0);
        drain_products();

        // Largest product: 64 results.
        load_dims(4'd8, 4'd8, 4'd8, 4'd8);
        issue_request(CMD_MUL, 3'd0, 3'd0, 32'h0);
        drain_products();

        // Random part.
        while (items_sent < 200) run_random_phase();

        if (fail_count == 0 && pending_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/mm_pkg.sv
rtl/core/mm_ram.sv
rtl/core/mm_datapath.sv
rtl/core/mm_ctrl.sv
rtl/core/matrix_multiply_top.sv
tb/matrix_multiply_checker.sv
tb/matrix_multiply_top_tb.sv
